### hdl/imucf_pkg.sv
// ----------------------------------------------------------------------------
// imucf_pkg: shared definitions of the IMU attitude complementary filter
// Fixed-point constants, configuration register indexes, sequencer states
// and the CORDIC arctangent step angles.
// ----------------------------------------------------------------------------
package imucf_pkg;

	localparam int ANGLE_W          = 16;
	localparam int ANGLE_FRAC       = 13;
	localparam int CORDIC_STEPS_DEF = 16;

	typedef logic signed [35:0] cw_t;

	localparam cw_t PI_Q30        = 36'sd3373259426;
	localparam cw_t HALF_PI_Q30   = 36'sd1686629713;
	localparam cw_t CORDIC_GAIN   = 36'sd652032875;
	localparam logic signed [24:0] GYRO_GAIN = 25'sd9585688;
	localparam logic signed [23:0] PI_A      = 24'sd25736;
	localparam logic [22:0]        TWO_PI_A  = 23'd51472;
	localparam logic signed [23:0] WRAP_BIAS = 24'sd1647104;
	localparam logic signed [15:0] COS_MIN   = 16'sd64;
	localparam logic [15:0]        BLEND_RESET = 16'd65274;

	typedef enum logic [2:0] {
		CFG_BLEND       = 3'd0,
		CFG_ROLL_OFS    = 3'd1,
		CFG_PITCH_OFS   = 3'd2,
		CFG_YAW_OFS     = 3'd3,
		CFG_START_ROLL  = 3'd4,
		CFG_START_PITCH = 3'd5
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_AR_LD, ST_CORD, ST_CPOST, ST_SQ_A, ST_SQ_B, ST_SQ_C,
		ST_SQRT, ST_AP_LD, ST_SR_LD, ST_SP_LD, ST_A_M1, ST_A_M2, ST_A_M3,
		ST_P_M2, ST_P_M3, ST_RDIV_LD, ST_DIV, ST_DPOST, ST_I_M1, ST_I_M2,
		ST_I_M3, ST_B_M1, ST_B_M2, ST_B_M3, ST_DONE
	} st_t;

	function automatic cw_t atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 36'sd843314857;
			5'd1:  atan_q30 = 36'sd497837830;
			5'd2:  atan_q30 = 36'sd263043837;
			5'd3:  atan_q30 = 36'sd133525159;
			5'd4:  atan_q30 = 36'sd67021687;
			5'd5:  atan_q30 = 36'sd33543515;
			5'd6:  atan_q30 = 36'sd16775850;
			5'd7:  atan_q30 = 36'sd8388437;
			5'd8:  atan_q30 = 36'sd4194283;
			5'd9:  atan_q30 = 36'sd2097150;
			5'd10: atan_q30 = 36'sd1048576;
			5'd11: atan_q30 = 36'sd524288;
			5'd12: atan_q30 = 36'sd262144;
			5'd13: atan_q30 = 36'sd131072;
			5'd14: atan_q30 = 36'sd65536;
			5'd15: atan_q30 = 36'sd32768;
			5'd16: atan_q30 = 36'sd16384;
			5'd17: atan_q30 = 36'sd8192;
			5'd18: atan_q30 = 36'sd4096;
			5'd19: atan_q30 = 36'sd2048;
			5'd20: atan_q30 = 36'sd1024;
			5'd21: atan_q30 = 36'sd512;
			5'd22: atan_q30 = 36'sd256;
			5'd23: atan_q30 = 36'sd128;
			5'd24: atan_q30 = 36'sd64;
			5'd25: atan_q30 = 36'sd32;
			5'd26: atan_q30 = 36'sd16;
			5'd27: atan_q30 = 36'sd8;
			5'd28: atan_q30 = 36'sd4;
			5'd29: atan_q30 = 36'sd2;
			5'd30: atan_q30 = 36'sd1;
			default: atan_q30 = 36'sd0;
		endcase
	endfunction

endpackage

### hdl/imu_attitude_complementary_filter_top.sv
// A zero accel denominator skips a CORDIC pass. A new input beat is accepted only after
// the previous result is loaded into the output register; one item is in flight at a time.
// Cost is set by one shared CORDIC unit (four passes), a 30-step square root,
// two 48-step divisions by cos(pitch) and a shared 34x25 multiplier.
// Reset (arst_n low, asynchronous) clears the sequencer and the output beat,
// sets blend_weight to 65274, offsets and all angle estimates to zero.
// ----------------------------------------------------------------------------
// imu_attitude_complementary_filter_top: Euler complementary attitude filter
// Removes gyro offsets, maps body rates to Euler rates, integrates and wraps
// roll, pitch and yaw, and blends roll and pitch with accelerometer angles.
// ----------------------------------------------------------------------------
module imu_attitude_complementary_filter_top #(
	parameter int CORDIC_STEPS = imucf_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// accel_x, accel_y, accel_z, rate_roll, rate_pitch, rate_yaw, step_time_us
	input  logic [119:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// roll_out, pitch_out, yaw_out
	output logic [47:0]  m_tdata,
	// rate_saturated
	output logic         m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	imucf_pkg::st_t state_q, state_d;

	logic [1:0] pass_q, ipass_q;
	logic       dpass_q, bpass_q;
	logic [5:0] it_q;

	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [16:0] r_q, p_q, w_q;
	logic [19:0]        dt_q;

	imucf_pkg::cw_t cx_q, cy_q, cz_q;
	logic           neg_q;
	logic [60:0]    sv_q, sr_q;

	logic signed [39:0] acc_q;
	logic signed [58:0] prod_q;
	logic signed [33:0] mul_a;
	logic signed [24:0] mul_b;

	logic signed [15:0] acc_roll_q, acc_pitch_q, s1_q, c1_q, s2_q, c2_q;
	logic signed [32:0] a_q;
	logic signed [31:0] rr_q, pr_q, yr_q;

	logic [47:0] dq_q;
	logic [16:0] rem_q;
	logic [14:0] dd_q;
	logic        qneg_q;

	logic signed [15:0] nr_q, np_q, roll_q, pitch_q, yaw_q;
	logic               sat_q;

	logic [15:0]        k_q;
	logic signed [15:0] off_r_q, off_p_q, off_y_q;

	logic        m_tvalid_q, out_sat_q;
	logic [47:0] out_data_q;

	logic in_fire, cfg_fire, out_load;

	// CORDIC, square root and divider step logic
	logic [4:0]      sh;
	imucf_pkg::cw_t  xs, ys, at;
	logic            plus;
	logic [6:0]      bsh;
	logic [60:0]     sb, rb;
	logic            sq_ge;
	logic [16:0]     rs;
	logic            dv_ge;
	logic signed [58:0] dnum, dmag, p1_w, dl_w;
	logic signed [23:0] vsum;
	logic signed [15:0] est_sel, sc_c, sc_s, zr;
	logic signed [16:0] den17, num17;
	logic signed [48:0] qv;
	logic signed [49:0] rr_sum, pr_sum;
	logic signed [39:0] bsum;
	logic signed [15:0] blend_res;

	function automatic logic signed [15:0] sc_q14(input imucf_pkg::cw_t v, input logic ng);
		imucf_pkg::cw_t vv, t;
		vv = ng ? -v : v;
		t = (vv + 36'sd32768) >>> 16;
		if (t > 36'sd16384)
			sc_q14 = 16'sd16384;
		else if (t < -36'sd16384)
			sc_q14 = -16'sd16384;
		else
			sc_q14 = t[15:0];
	endfunction

	function automatic logic signed [31:0] clamp_rate(input logic signed [49:0] v);
		if (v > 50'sd2147483647)
			clamp_rate = 32'sh7fffffff;
		else if (v < -50'sd2147483647)
			clamp_rate = 32'sh80000001;
		else
			clamp_rate = v[31:0];
	endfunction

	function automatic logic rate_ovf(input logic signed [49:0] v);
		rate_ovf = (v > 50'sd2147483647) || (v < -50'sd2147483647);
	endfunction

	function automatic logic signed [15:0] wrap_angle(input logic signed [23:0] v);
		logic [22:0]        u;
		logic signed [23:0] b;
		b = v + imucf_pkg::WRAP_BIAS;
		u = b[22:0];
		for (int j = 5; j >= 0; j--) begin
			if (u >= (imucf_pkg::TWO_PI_A << j))
				u = u - (imucf_pkg::TWO_PI_A << j);
		end
		wrap_angle = u[15:0] - 16'd25736;
	endfunction

	assign in_fire  = s_tvalid && s_tready;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign out_load = (state_q == imucf_pkg::ST_DONE) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sat_q;

	always_comb begin
		sh    = it_q[4:0];
		xs    = cx_q >>> sh;
		ys    = cy_q >>> sh;
		at    = imucf_pkg::atan_q30(sh);
		plus  = pass_q[1] ? cz_q[35] : !cy_q[35];
		bsh   = 7'd58 - {it_q, 1'b0};
		sb    = 61'd1 << bsh;
		rb    = sr_q + sb;
		sq_ge = sv_q >= rb;
		rs    = {rem_q[15:0], dq_q[47]};
		dv_ge = rs >= {2'b00, dd_q};
		dnum  = (state_q == imucf_pkg::ST_RDIV_LD) ? prod_q : (59'(a_q) <<< 14);
		dmag  = dnum[58] ? -dnum : dnum;
		p1_w  = (prod_q + 59'sd8388608) >>> 24;
		dl_w  = (prod_q + 59'sd536870912) >>> 30;
		case (ipass_q)
			2'd0:    est_sel = roll_q;
			2'd1:    est_sel = pitch_q;
			default: est_sel = yaw_q;
		endcase
		vsum   = 24'(est_sel) + dl_w[23:0] + imucf_pkg::PI_A;
		sc_c   = sc_q14(cx_q, neg_q);
		sc_s   = sc_q14(cy_q, neg_q);
		zr     = 16'((cz_q + 36'sd65536) >>> 17);
		den17  = az_q[15] ? -17'(az_q) : 17'(az_q);
		num17  = az_q[15] ? -17'(ay_q) : 17'(ay_q);
		qv     = qneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
		rr_sum = (50'(r_q) <<< 14) + 50'(qv);
		pr_sum = 50'(acc_q - 40'(prod_q));
		bsum   = acc_q + 40'(prod_q);
		blend_res = 16'((bsum + 40'sd32768) >>> 16);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			imucf_pkg::ST_IDLE:    if (s_tvalid) state_d = imucf_pkg::ST_AR_LD;
			imucf_pkg::ST_AR_LD:   state_d = (az_q == '0) ? imucf_pkg::ST_CPOST : imucf_pkg::ST_CORD;
			imucf_pkg::ST_CORD:    if (it_q == 6'(CORDIC_STEPS - 1)) state_d = imucf_pkg::ST_CPOST;
			imucf_pkg::ST_CPOST: begin
				case (pass_q)
					2'd0:    state_d = imucf_pkg::ST_SQ_A;
					2'd1:    state_d = imucf_pkg::ST_SR_LD;
					2'd2:    state_d = imucf_pkg::ST_SP_LD;
					default: state_d = imucf_pkg::ST_A_M1;
				endcase
			end
			imucf_pkg::ST_SQ_A:    state_d = imucf_pkg::ST_SQ_B;
			imucf_pkg::ST_SQ_B:    state_d = imucf_pkg::ST_SQ_C;
			imucf_pkg::ST_SQ_C:    state_d = imucf_pkg::ST_SQRT;
			imucf_pkg::ST_SQRT:    if (it_q == 6'd29) state_d = imucf_pkg::ST_AP_LD;
			imucf_pkg::ST_AP_LD:   state_d = (sr_q == '0) ? imucf_pkg::ST_CPOST : imucf_pkg::ST_CORD;
			imucf_pkg::ST_SR_LD:   state_d = imucf_pkg::ST_CORD;
			imucf_pkg::ST_SP_LD:   state_d = imucf_pkg::ST_CORD;
			imucf_pkg::ST_A_M1:    state_d = imucf_pkg::ST_A_M2;
			imucf_pkg::ST_A_M2:    state_d = imucf_pkg::ST_A_M3;
			imucf_pkg::ST_A_M3:    state_d = imucf_pkg::ST_P_M2;
			imucf_pkg::ST_P_M2:    state_d = imucf_pkg::ST_P_M3;
			imucf_pkg::ST_P_M3:    state_d = imucf_pkg::ST_RDIV_LD;
			imucf_pkg::ST_RDIV_LD: state_d = imucf_pkg::ST_DIV;
			imucf_pkg::ST_DIV:     if (it_q == 6'd47) state_d = imucf_pkg::ST_DPOST;
			imucf_pkg::ST_DPOST:   state_d = dpass_q ? imucf_pkg::ST_I_M1 : imucf_pkg::ST_DIV;
			imucf_pkg::ST_I_M1:    state_d = imucf_pkg::ST_I_M2;
			imucf_pkg::ST_I_M2:    state_d = imucf_pkg::ST_I_M3;
			imucf_pkg::ST_I_M3:    state_d = (ipass_q == 2'd2) ? imucf_pkg::ST_B_M1 : imucf_pkg::ST_I_M1;
			imucf_pkg::ST_B_M1:    state_d = imucf_pkg::ST_B_M2;
			imucf_pkg::ST_B_M2:    state_d = imucf_pkg::ST_B_M3;
			imucf_pkg::ST_B_M3:    state_d = bpass_q ? imucf_pkg::ST_DONE : imucf_pkg::ST_B_M1;
			imucf_pkg::ST_DONE:    if (out_load) state_d = imucf_pkg::ST_IDLE;
			default:               state_d = imucf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == imucf_pkg::ST_IDLE);
		cfg_ready = 1'b1;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			imucf_pkg::ST_SQ_A: begin mul_a = 34'(ay_q); mul_b = 25'(ay_q); end
			imucf_pkg::ST_SQ_B: begin mul_a = 34'(az_q); mul_b = 25'(az_q); end
			imucf_pkg::ST_A_M1: begin mul_a = 34'(p_q);  mul_b = 25'(s1_q); end
			imucf_pkg::ST_A_M2: begin mul_a = 34'(w_q);  mul_b = 25'(c1_q); end
			imucf_pkg::ST_A_M3: begin mul_a = 34'(p_q);  mul_b = 25'(c1_q); end
			imucf_pkg::ST_P_M2: begin mul_a = 34'(w_q);  mul_b = 25'(s1_q); end
			imucf_pkg::ST_P_M3: begin mul_a = 34'(a_q);  mul_b = 25'(s2_q); end
			imucf_pkg::ST_I_M1: begin
				case (ipass_q)
					2'd0:    mul_a = 34'(rr_q);
					2'd1:    mul_a = 34'(pr_q);
					default: mul_a = 34'(yr_q);
				endcase
				mul_b = $signed({5'b0, dt_q});
			end
			imucf_pkg::ST_I_M2: begin mul_a = p1_w[33:0]; mul_b = imucf_pkg::GYRO_GAIN; end
			imucf_pkg::ST_B_M1: begin
				mul_a = $signed({18'b0, k_q});
				mul_b = bpass_q ? 25'(np_q) : 25'(nr_q);
			end
			imucf_pkg::ST_B_M2: begin
				mul_a = 34'(18'sh10000 - $signed({2'b00, k_q}));
				mul_b = bpass_q ? 25'(acc_pitch_q) : 25'(acc_roll_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= imucf_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
			k_q        <= imucf_pkg::BLEND_RESET;
			off_r_q    <= '0;
			off_p_q    <= '0;
			off_y_q    <= '0;
			roll_q     <= '0;
			pitch_q    <= '0;
			yaw_q      <= '0;
			sat_q      <= 1'b0;
			it_q       <= '0;
			pass_q     <= '0;
			ipass_q    <= '0;
			dpass_q    <= 1'b0;
			bpass_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (cfg_fire) begin
				case (cfg_index)
					imucf_pkg::CFG_BLEND:       k_q     <= cfg_data;
					imucf_pkg::CFG_ROLL_OFS:    off_r_q <= cfg_data;
					imucf_pkg::CFG_PITCH_OFS:   off_p_q <= cfg_data;
					imucf_pkg::CFG_YAW_OFS:     off_y_q <= cfg_data;
					imucf_pkg::CFG_START_ROLL:  roll_q  <= cfg_data;
					imucf_pkg::CFG_START_PITCH: pitch_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				imucf_pkg::ST_IDLE:    if (in_fire) sat_q <= 1'b0;
				imucf_pkg::ST_AR_LD: begin pass_q <= 2'd0; it_q <= '0; end
				imucf_pkg::ST_AP_LD: begin pass_q <= 2'd1; it_q <= '0; end
				imucf_pkg::ST_SR_LD: begin pass_q <= 2'd2; it_q <= '0; end
				imucf_pkg::ST_SP_LD: begin pass_q <= 2'd3; it_q <= '0; end
				imucf_pkg::ST_CORD:  it_q <= it_q + 6'd1;
				imucf_pkg::ST_SQ_C:  it_q <= '0;
				imucf_pkg::ST_SQRT:  it_q <= it_q + 6'd1;
				imucf_pkg::ST_CPOST: begin
					if (pass_q == 2'd3 && sc_c > -imucf_pkg::COS_MIN && sc_c < imucf_pkg::COS_MIN)
						sat_q <= 1'b1;
				end
				imucf_pkg::ST_P_M3:    if (rate_ovf(pr_sum)) sat_q <= 1'b1;
				imucf_pkg::ST_RDIV_LD: begin dpass_q <= 1'b0; it_q <= '0; end
				imucf_pkg::ST_DIV:     it_q <= it_q + 6'd1;
				imucf_pkg::ST_DPOST: begin
					it_q    <= '0;
					dpass_q <= 1'b1;
					ipass_q <= '0;
					if (dpass_q ? rate_ovf(50'(qv)) : rate_ovf(rr_sum))
						sat_q <= 1'b1;
				end
				imucf_pkg::ST_I_M3: begin
					ipass_q <= ipass_q + 2'd1;
					bpass_q <= 1'b0;
					if (ipass_q == 2'd2)
						yaw_q <= wrap_angle(vsum);
				end
				imucf_pkg::ST_B_M3: begin
					bpass_q <= 1'b1;
					if (bpass_q)
						pitch_q <= blend_res;
					else
						roll_q <= blend_res;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (out_load) begin
			out_data_q <= {yaw_q, pitch_q, roll_q};
			out_sat_q  <= sat_q;
		end
		case (state_q)
			imucf_pkg::ST_IDLE: begin
				if (in_fire) begin
					ax_q <= s_tdata[15:0];
					ay_q <= s_tdata[31:16];
					az_q <= s_tdata[47:32];
					r_q  <= 17'($signed(s_tdata[63:48])) - 17'(off_r_q);
					p_q  <= 17'($signed(s_tdata[79:64])) - 17'(off_p_q);
					w_q  <= 17'($signed(s_tdata[95:80])) - 17'(off_y_q);
					dt_q <= s_tdata[115:96];
				end
			end
			imucf_pkg::ST_AR_LD: begin
				cx_q <= 36'(den17) <<< 14;
				cy_q <= 36'(num17) <<< 14;
				if (az_q == '0)
					cz_q <= (ay_q > 0) ? imucf_pkg::HALF_PI_Q30 :
						((ay_q < 0) ? -imucf_pkg::HALF_PI_Q30 : '0);
				else
					cz_q <= '0;
			end
			imucf_pkg::ST_AP_LD: begin
				cx_q <= 36'(sr_q[29:0]);
				cy_q <= 36'(ax_q) <<< 14;
				if (sr_q == '0)
					cz_q <= (ax_q > 0) ? imucf_pkg::HALF_PI_Q30 :
						((ax_q < 0) ? -imucf_pkg::HALF_PI_Q30 : '0);
				else
					cz_q <= '0;
			end
			imucf_pkg::ST_SR_LD, imucf_pkg::ST_SP_LD: begin
				imucf_pkg::cw_t z0;
				z0 = (state_q == imucf_pkg::ST_SR_LD) ? (36'(roll_q) <<< 17) : (36'(pitch_q) <<< 17);
				cx_q <= imucf_pkg::CORDIC_GAIN;
				cy_q <= '0;
				if (z0 > imucf_pkg::HALF_PI_Q30) begin
					cz_q  <= z0 - imucf_pkg::PI_Q30;
					neg_q <= 1'b1;
				end else if (z0 < -imucf_pkg::HALF_PI_Q30) begin
					cz_q  <= z0 + imucf_pkg::PI_Q30;
					neg_q <= 1'b1;
				end else begin
					cz_q  <= z0;
					neg_q <= 1'b0;
				end
			end
			imucf_pkg::ST_CORD: begin
				if (plus) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end
			end
			imucf_pkg::ST_CPOST: begin
				case (pass_q)
					2'd0: acc_roll_q  <= zr;
					2'd1: acc_pitch_q <= zr;
					2'd2: begin s1_q <= sc_s; c1_q <= sc_c; end
					default: begin
						s2_q <= sc_s;
						if (sc_c > -imucf_pkg::COS_MIN && sc_c < imucf_pkg::COS_MIN)
							c2_q <= sc_c[15] ? -imucf_pkg::COS_MIN : imucf_pkg::COS_MIN;
						else
							c2_q <= sc_c;
					end
				endcase
			end
			imucf_pkg::ST_SQ_B: acc_q <= 40'(prod_q);
			imucf_pkg::ST_SQ_C: begin
				logic signed [39:0] ssum;
				ssum = acc_q + 40'(prod_q);
				sv_q <= 61'(ssum[31:0]) << 28;
				sr_q <= '0;
			end
			imucf_pkg::ST_SQRT: begin
				if (sq_ge) begin
					sv_q <= sv_q - rb;
					sr_q <= (sr_q >> 1) + sb;
				end else begin
					sr_q <= sr_q >> 1;
				end
			end
			imucf_pkg::ST_A_M2: acc_q <= 40'(prod_q);
			imucf_pkg::ST_A_M3: a_q <= 33'(acc_q + 40'(prod_q));
			imucf_pkg::ST_P_M2: acc_q <= 40'(prod_q);
			imucf_pkg::ST_P_M3: pr_q <= clamp_rate(pr_sum);
			imucf_pkg::ST_RDIV_LD: begin
				dq_q   <= dmag[47:0];
				rem_q  <= '0;
				dd_q   <= c2_q[15] ? 15'(-c2_q) : c2_q[14:0];
				qneg_q <= dnum[58] ^ c2_q[15];
			end
			imucf_pkg::ST_DIV: begin
				rem_q <= dv_ge ? (rs - {2'b00, dd_q}) : rs;
				dq_q  <= {dq_q[46:0], dv_ge};
			end
			imucf_pkg::ST_DPOST: begin
				if (dpass_q) begin
					yr_q <= clamp_rate(50'(qv));
				end else begin
					rr_q   <= clamp_rate(rr_sum);
					dq_q   <= dmag[47:0];
					rem_q  <= '0;
					qneg_q <= dnum[58] ^ c2_q[15];
				end
			end
			imucf_pkg::ST_I_M3: begin
				if (ipass_q == 2'd0)
					nr_q <= wrap_angle(vsum);
				else if (ipass_q == 2'd1)
					np_q <= wrap_angle(vsum);
			end
			imucf_pkg::ST_B_M2: acc_q <= 40'(prod_q);
			default: ;
		endcase
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("input accepted twice without a busy period");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == imucf_pkg::ST_DONE))
		else $error("result beat raised outside the completion step");

	a_cordic_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == imucf_pkg::ST_CORD |-> it_q < 6'(CORDIC_STEPS))
		else $error("CORDIC iteration count overran");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == imucf_pkg::ST_DIV |-> dd_q >= 15'd64)
		else $error("divisor below cos clamp");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the IMU attitude complementary filter
// A queue-fed stream driver and a checking monitor run against an attitude
// predictor kept in step with every accepted beat. Register settings change
// between phases, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCH_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam int TAIL_CYCLES = 300;

	typedef struct {
		logic signed [15:0] ax, ay, az, gr, gp, gy;
		logic [19:0] dt;
	} imu_item_t;

	typedef struct {
		logic signed [15:0] roll, pitch, yaw;
		logic sat;
	} attitude_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [119:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	imu_item_t samples_q[$];
	attitude_t attitude_q[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_cnt = 0;
	int errors = 0;
	int quiet_cycles = 0;

	// filter state
	longint k_w, ofs_r, ofs_p, ofs_y, est_r, est_p, est_y;
	longint atan_steps[16] = '{843314857, 497837830, 263043837, 133525159, 67021687,
		33543515, 16775850, 8388437, 4194283, 2097150, 1048576, 524288, 262144,
		131072, 65536, 32768};

	imu_attitude_complementary_filter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint round_shift(longint v, int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic void rotate_sincos(longint ang, output longint s, output longint c);
		longint z, x, y, t;
		bit flip;
		z = ang * (longint'(1) << 17);
		x = 64'sd652032875;
		y = 0;
		flip = 0;
		if (z > 64'sd1686629713) begin
			z -= 64'sd3373259426;
			flip = 1;
		end else if (z < -64'sd1686629713) begin
			z += 64'sd3373259426;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			t = x;
			if (z >= 0) begin
				x -= y >>> i; y += t >>> i; z -= atan_steps[i];
			end else begin
				x += y >>> i; y -= t >>> i; z += atan_steps[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		x = round_shift(x, 16);
		y = round_shift(y, 16);
		if (x > 16384) x = 16384;
		if (x < -16384) x = -16384;
		if (y > 16384) y = 16384;
		if (y < -16384) y = -16384;
		s = y;
		c = x;
	endfunction

	function automatic longint vector_atan(longint num, longint den);
		longint x, y, z, t;
		x = den;
		y = num;
		z = 0;
		if (den == 0)
			z = num > 0 ? 64'sd1686629713 : (num < 0 ? -64'sd1686629713 : 64'sd0);
		else
			for (int i = 0; i < 16; i++) begin
				t = x;
				if (y >= 0) begin
					x += y >>> i; y -= t >>> i; z += atan_steps[i];
				end else begin
					x -= y >>> i; y += t >>> i; z -= atan_steps[i];
				end
			end
		return round_shift(z, 17);
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint limit_rate(longint v, ref bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483647) begin
			sat = 1;
			return -64'sd2147483647;
		end
		return v;
	endfunction

	function automatic longint advance_angle(longint est, longint rate, longint dt);
		longint p1, v, m;
		p1 = round_shift(rate * dt, 24);
		v = est + round_shift(p1 * 9585688, 30) + 25736;
		m = v % 51472;
		if (m < 0) m += 51472;
		return m - 25736;
	endfunction

	function automatic longint mix(longint g, longint a);
		return round_shift(k_w * g + (65536 - k_w) * a, 16);
	endfunction

	function automatic attitude_t predict_attitude(imu_item_t it);
		longint ax, ay, az, r, p, y, dt, s1, c1, s2, c2, a, rr, pr, yr;
		longint acc_roll, acc_pitch, num, den;
		bit sat;
		attitude_t res;
		ax = longint'(it.ax); ay = longint'(it.ay); az = longint'(it.az);
		r = longint'(it.gr) - ofs_r;
		p = longint'(it.gp) - ofs_p;
		y = longint'(it.gy) - ofs_y;
		dt = longint'(it.dt);
		sat = 0;
		num = ay * 16384;
		den = az * 16384;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		acc_roll = vector_atan(num, den);
		den = int_sqrt(longint'(ay * ay + az * az) << 28);
		acc_pitch = vector_atan(ax * 16384, den);
		rotate_sincos(est_r, s1, c1);
		rotate_sincos(est_p, s2, c2);
		if (c2 < 64 && c2 > -64) begin
			c2 = c2 < 0 ? -64 : 64;
			sat = 1;
		end
		a = p * s1 + y * c1;
		rr = limit_rate(r * 16384 + (a * s2) / c2, sat);
		pr = limit_rate(p * c1 - y * s1, sat);
		yr = limit_rate((a * 16384) / c2, sat);
		est_r = mix(advance_angle(est_r, rr, dt), acc_roll);
		est_p = mix(advance_angle(est_p, pr, dt), acc_pitch);
		est_y = advance_angle(est_y, yr, dt);
		res.roll = est_r[15:0];
		res.pitch = est_p[15:0];
		res.yaw = est_y[15:0];
		res.sat = sat;
		return res;
	endfunction

	// stream driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				attitude_q.push_back(predict_attitude('{
					ax: s_tdata[15:0], ay: s_tdata[31:16], az: s_tdata[47:32],
					gr: s_tdata[63:48], gp: s_tdata[79:64], gy: s_tdata[95:80],
					dt: s_tdata[115:96]}));
			end
			if (!s_tvalid || s_tready) begin
				if (samples_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					imu_item_t it;
					it = samples_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, it.dt, it.gy, it.gp, it.gr, it.az, it.ay, it.ax};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (attitude_q.size() == 0) begin
					$error("result beat with nothing expected: %h %b", m_tdata, m_tuser);
					errors++;
				end else begin
					attitude_t e;
					e = attitude_q.pop_front();
					if (m_tdata[15:0] !== e.roll) begin
						$error("roll_out expected %0d got %0d", e.roll, $signed(m_tdata[15:0]));
						errors++;
					end
					if (m_tdata[31:16] !== e.pitch) begin
						$error("pitch_out expected %0d got %0d", e.pitch,
							$signed(m_tdata[31:16]));
						errors++;
					end
					if (m_tdata[47:32] !== e.yaw) begin
						$error("yaw_out expected %0d got %0d", e.yaw, $signed(m_tdata[47:32]));
						errors++;
					end
					if (m_tuser !== e.sat) begin
						$error("rate_saturated expected %0d got %0d", e.sat, m_tuser);
						errors++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| (samples_q.size() == 0 && attitude_q.size() == 0 && !s_tvalid))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(imucf_pkg::cfg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			imucf_pkg::CFG_BLEND: k_w = longint'(val);
			imucf_pkg::CFG_ROLL_OFS: ofs_r = longint'($signed(val));
			imucf_pkg::CFG_PITCH_OFS: ofs_p = longint'($signed(val));
			imucf_pkg::CFG_YAW_OFS: ofs_y = longint'($signed(val));
			imucf_pkg::CFG_START_ROLL: est_r = longint'($signed(val));
			imucf_pkg::CFG_START_PITCH: est_p = longint'($signed(val));
			default: ;
		endcase
	endtask

	task automatic drain();
		while (samples_q.size() > 0 || attitude_q.size() > 0 || s_tvalid) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic add(int ax, int ay, int az, int gr, int gp, int gy, int dt);
		imu_item_t it;
		it.ax = 16'(ax); it.ay = 16'(ay); it.az = 16'(az);
		it.gr = 16'(gr); it.gp = 16'(gp); it.gy = 16'(gy);
		it.dt = 20'(dt);
		samples_q.push_back(it);
	endtask

	task automatic add_random(int n);
		imu_item_t it;
		repeat (n) begin
			it.ax = 16'($urandom);
			it.ay = 16'($urandom);
			it.az = 16'($urandom);
			if ($urandom_range(9) < 7) begin
				it.gr = $signed(16'($urandom_range(4000))) - 16'sd2000;
				it.gp = $signed(16'($urandom_range(4000))) - 16'sd2000;
				it.gy = $signed(16'($urandom_range(4000))) - 16'sd2000;
				it.dt = 20'($urandom_range(20000));
			end else begin
				it.gr = 16'($urandom);
				it.gp = 16'($urandom);
				it.gy = 16'($urandom);
				it.dt = 20'($urandom);
			end
			samples_q.push_back(it);
		end
	endtask

	initial begin
		k_w = 65274;
		ofs_r = 0; ofs_p = 0; ofs_y = 0;
		est_r = 0; est_p = 0; est_y = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, zero denominators, negative z, zero step, wrap
		add(0, 0, 0, 0, 0, 0, 0);
		add(32767, 32767, 32767, 32767, 32767, 32767, 1048575);
		add(-32768, -32768, -32768, -32768, -32768, -32768, 1048575);
		add(100, 500, 0, 0, 0, 0, 1000);
		add(100, -500, 0, 0, 0, 0, 1000);
		add(3000, 0, 0, 0, 0, 0, 1000);
		add(-3000, 0, 0, 0, 0, 0, 1000);
		add(0, 1200, -16000, 100, -100, 50, 2500);
		add(0, -1200, -16000, 100, -100, 50, 2500);
		add(0, 0, 16384, 500, 500, 500, 0);
		add(0, 0, 16384, 32767, 0, 32767, 1048575);
		add(0, 0, 16384, -32768, 0, -32768, 1048575);
		drain();

		// pitch parked at +pi/2 to force the cos clamp and rate limits
		write_reg(imucf_pkg::CFG_BLEND, 16'd65535);
		write_reg(imucf_pkg::CFG_START_ROLL, 16'h9b78);
		write_reg(imucf_pkg::CFG_START_PITCH, 16'd12868);
		write_reg(imucf_pkg::CFG_ROLL_OFS, 16'h8000);
		write_reg(imucf_pkg::CFG_PITCH_OFS, 16'h7fff);
		write_reg(imucf_pkg::CFG_YAW_OFS, 16'h8000);
		add(0, 0, 16384, 0, 0, 0, 0);
		add(16000, 0, 100, 32767, -32768, 32767, 5000);
		add(16000, 0, 100, -32768, 32767, -32768, 1048575);
		drain();
		write_reg(imucf_pkg::CFG_START_PITCH, 16'hcdbc);
		add(-16000, 0, 100, 0, 0, 0, 2000);
		add(-16000, 0, 100, 1000, 1000, 1000, 0);
		drain();

		write_reg(imucf_pkg::CFG_BLEND, 16'd0);
		write_reg(imucf_pkg::CFG_ROLL_OFS, 16'h7fff);
		write_reg(imucf_pkg::CFG_PITCH_OFS, 16'h8000);
		write_reg(imucf_pkg::CFG_YAW_OFS, 16'h7fff);
		write_reg(imucf_pkg::CFG_START_ROLL, 16'd25735);
		write_reg(imucf_pkg::CFG_START_PITCH, 16'h9b78);
		add_random(240);
		drain();

		write_reg(imucf_pkg::CFG_BLEND, 16'd65274);
		write_reg(imucf_pkg::CFG_ROLL_OFS, 16'd12);
		write_reg(imucf_pkg::CFG_PITCH_OFS, -16'sd7);
		write_reg(imucf_pkg::CFG_YAW_OFS, 16'd3);
		write_reg(imucf_pkg::CFG_START_ROLL, 16'd0);
		write_reg(imucf_pkg::CFG_START_PITCH, 16'd0);
		send_idle_pct = 87;
		add_random(240);
		drain();

		write_reg(imucf_pkg::CFG_BLEND, 16'($urandom));
		write_reg(imucf_pkg::CFG_START_PITCH, 16'($urandom_range(25735)));
		send_idle_pct = 0;
		recv_stall_pct = 87;
		hold_req <= 1'b1;
		add_random(240);
		drain();

		write_reg(imucf_pkg::CFG_BLEND, 16'd60000);
		write_reg(imucf_pkg::CFG_ROLL_OFS, 16'($urandom));
		write_reg(imucf_pkg::CFG_START_ROLL, -16'sd12000);
		send_idle_pct = 38;
		recv_stall_pct = 38;
		add_random(240);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		add_random(240);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && attitude_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### sim.f
hdl/imucf_pkg.sv
hdl/imu_attitude_complementary_filter_top.sv
tb/tb.sv
